>>> src/fsd_pkg.sv
// Shared types and constants for the flow slot demux with aging.
package fsd_pkg;

    localparam int unsigned FLOW_SLOTS_DEF = 8;
    localparam int unsigned ADDR_W        = 32;
    localparam int unsigned PORT_W        = 16;
    localparam int unsigned TIME_W        = 32;
    localparam int unsigned PROTO_W       = 8;
    localparam int unsigned TIMEOUT_W     = 16;
    localparam int unsigned SLOT_IDX_W    = 3;
    localparam int unsigned ROUTE_W       = 2;

    localparam logic [PROTO_W-1:0]   UDP_PROTO_NUM = 8'd17;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd3;

    localparam logic [ROUTE_W-1:0] ROUTE_SLOT     = 2'd0;
    localparam logic [ROUTE_W-1:0] ROUTE_BAD      = 2'd1;
    localparam logic [ROUTE_W-1:0] ROUTE_OVERFLOW = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_COMMIT
    } state_t;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [PORT_W-1:0] port;
        logic [TIME_W-1:0] now;
    } hdr_t;

    typedef struct packed {
        logic eval;
        logic commit;
    } cell_ctrl_t;

    typedef struct packed {
        logic                  hit;
        logic                  free;
        logic [SLOT_IDX_W-1:0] idx;
    } row_res_t;

endpackage

>>> src/fsd_cell.sv
// One flow slot: stored key and last-seen time, local match and age test.
module fsd_cell (
    input  logic                           clk,
    input  logic                           rst_n,
    input  fsd_pkg::hdr_t                  hdr,
    input  logic [fsd_pkg::TIMEOUT_W-1:0]  timeout,
    input  fsd_pkg::cell_ctrl_t            ctrl,
    input  logic                           any_hit,
    input  logic                           hit_in,
    input  logic                           free_in,
    output logic                           hit_out,
    output logic                           free_out,
    output logic                           grant
);
    import fsd_pkg::*;

    logic [ADDR_W-1:0] addr_reg;
    logic [PORT_W-1:0] port_reg;
    logic [TIME_W-1:0] seen_reg;
    logic              valid_reg;
    logic              match_reg;
    logic              free_reg;

    logic [TIME_W-1:0] age;
    logic              match_next;
    logic              free_next;
    logic              hit_grant;
    logic              claim_grant;

    assign age        = hdr.now - seen_reg;
    assign match_next = valid_reg && (addr_reg == hdr.addr) && (port_reg == hdr.port);
    assign free_next  = !valid_reg || (age > {{(TIME_W-TIMEOUT_W){1'b0}}, timeout});

    assign hit_grant   = match_reg && !hit_in;
    assign claim_grant = free_reg && !free_in && !any_hit;
    assign grant       = hit_grant || claim_grant;
    assign hit_out     = hit_in || match_reg;
    assign free_out    = free_in || free_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctrl.commit && claim_grant)
        begin
            valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.eval)
        begin
            match_reg <= match_next;
            free_reg  <= free_next;
        end
        if (ctrl.commit && hit_grant)
        begin
            seen_reg <= hdr.now;
        end
        else if (ctrl.commit && claim_grant)
        begin
            addr_reg <= hdr.addr;
            port_reg <= hdr.port;
            seen_reg <= hdr.now;
        end
    end

endmodule

>>> src/fsd_cell_row.sv
// Row of flow slot cells chained by lowest-index-wins priority.
module fsd_cell_row #(
    parameter int unsigned FLOW_SLOTS = fsd_pkg::FLOW_SLOTS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  fsd_pkg::hdr_t                  hdr,
    input  logic [fsd_pkg::TIMEOUT_W-1:0]  timeout,
    input  fsd_pkg::cell_ctrl_t            ctrl,
    output fsd_pkg::row_res_t              res
);
    import fsd_pkg::*;

    logic [FLOW_SLOTS:0]   hit_chain;
    logic [FLOW_SLOTS:0]   free_chain;
    logic [FLOW_SLOTS-1:0] grant;
    logic                  any_hit;
    logic [SLOT_IDX_W-1:0] idx;

    assign hit_chain[0]  = 1'b0;
    assign free_chain[0] = 1'b0;
    assign any_hit       = hit_chain[FLOW_SLOTS];

    for (genvar g = 0; g < FLOW_SLOTS; g++)
    begin : g_cell
        fsd_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .hdr      (hdr),
            .timeout  (timeout),
            .ctrl     (ctrl),
            .any_hit  (any_hit),
            .hit_in   (hit_chain[g]),
            .free_in  (free_chain[g]),
            .hit_out  (hit_chain[g+1]),
            .free_out (free_chain[g+1]),
            .grant    (grant[g])
        );
    end

    always_comb
    begin
        idx = '0;
        for (int i = 0; i < FLOW_SLOTS; i++)
        begin
            if (grant[i])
            begin
                idx = idx | SLOT_IDX_W'(i);
            end
        end
    end

    assign res.hit  = any_hit;
    assign res.free = free_chain[FLOW_SLOTS];
    assign res.idx  = idx;

endmodule

>>> src/flow_slot_demux_with_aging.sv
// Top level: header capture, sequencing, timeout register and result register.
// Per header: capture, slot test, commit; the commit registers the result beat.
// Headers wait for the prior commit; the commit waits while a result beat is held.
// The slot test and pick run across the cell row; the commit updates the winning cell.
// Reset clears all slot valid bits (all slots free) and out_valid, sets timeout to 3.
module flow_slot_demux_with_aging #(
    parameter int unsigned FLOW_SLOTS = fsd_pkg::FLOW_SLOTS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [fsd_pkg::TIMEOUT_W-1:0]   cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            has_ip_header,
    input  logic [fsd_pkg::PROTO_W-1:0]     ip_protocol,
    input  logic [fsd_pkg::ADDR_W-1:0]      dest_ip,
    input  logic [fsd_pkg::PORT_W-1:0]      dst_port,
    input  logic [fsd_pkg::TIME_W-1:0]      now_seconds,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [fsd_pkg::ROUTE_W-1:0]     route_kind,
    output logic [fsd_pkg::SLOT_IDX_W-1:0]  slot_index,
    output logic                            newly_claimed
);
    import fsd_pkg::*;

    state_t                state_reg;
    state_t                state_next;
    logic [TIMEOUT_W-1:0]  timeout_reg;
    hdr_t                  hdr_reg;
    logic                  bad_reg;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [ROUTE_W-1:0]    route_reg;
    logic [ROUTE_W-1:0]    route_next;
    logic [SLOT_IDX_W-1:0] idx_reg;
    logic [SLOT_IDX_W-1:0] idx_next;
    logic                  claimed_reg;
    logic                  claimed_next;
    logic                  accept;
    logic                  commit;
    cell_ctrl_t            ctrl;
    row_res_t              res;

    fsd_cell_row #(
        .FLOW_SLOTS (FLOW_SLOTS)
    ) u_row (
        .clk     (clk),
        .rst_n   (rst_n),
        .hdr     (hdr_reg),
        .timeout (timeout_reg),
        .ctrl    (ctrl),
        .res     (res)
    );

    assign cfg_ready     = 1'b1;
    assign out_valid     = out_valid_reg;
    assign route_kind    = route_reg;
    assign slot_index    = idx_reg;
    assign newly_claimed = claimed_reg;

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        commit     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    commit     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign accept      = in_valid && in_ready;
    assign ctrl.eval   = (state_reg == ST_EVAL);
    assign ctrl.commit = commit && !bad_reg;

    always_comb
    begin
        route_next   = ROUTE_OVERFLOW;
        idx_next     = '0;
        claimed_next = 1'b0;
        priority if (bad_reg)
        begin
            route_next = ROUTE_BAD;
        end
        else if (res.hit)
        begin
            route_next = ROUTE_SLOT;
            idx_next   = res.idx;
        end
        else if (res.free)
        begin
            route_next   = ROUTE_SLOT;
            idx_next     = res.idx;
            claimed_next = 1'b1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            timeout_reg   <= TIMEOUT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                timeout_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hdr_reg.addr <= dest_ip;
            hdr_reg.port <= dst_port;
            hdr_reg.now  <= now_seconds;
            bad_reg      <= !has_ip_header || (ip_protocol != UDP_PROTO_NUM);
        end
        if (commit)
        begin
            route_reg   <= route_next;
            idx_reg     <= idx_next;
            claimed_reg <= claimed_next;
        end
    end

endmodule
